FILE: design/pddi_pkg.sv
`timescale 1ns / 1ps

package pddi_pkg;

  // default sizes of the top level
  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_TIME_BITS   = 48;
  localparam int DEF_HANDLE_BITS = 16;

  // request buffer between front and back
  localparam int CMDQ_DEPTH = 2;

  localparam int MS_PER_S  = 1000;
  localparam int SEC_BITS  = 16;
  localparam int MS_BITS   = SEC_BITS + 10;
  localparam int PCT_BITS  = 7;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // request codes
  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // result actions
  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_DROP    = 2'd1;
  localparam logic [1:0] ACT_QUEUE   = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DROP_ON         = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DROP_BY_PERCENT = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DROPS_PER_SEC   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DROP_CHANCE     = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DELAY_ON        = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW_PERIOD   = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW_BURST    = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_HOLD_SECONDS    = 3'd7;

  typedef struct packed {
    logic                drop_on;
    logic                drop_by_percent;
    logic [SEC_BITS-1:0] drops_per_second;
    logic [PCT_BITS-1:0] drop_chance;
    logic                delay_on;
    logic [SEC_BITS-1:0] window_period_s;
    logic [SEC_BITS-1:0] window_burst_s;
    logic [SEC_BITS-1:0] hold_seconds;
  } cfg_t;

  // classified request
  typedef struct packed {
    logic                is_pkt;
    logic                is_flush;
    logic                hit;
    logic [PCT_BITS-1:0] rnd;
  } cmd_ctl_t;

  function automatic logic [MS_BITS-1:0] sec_to_ms(input logic [SEC_BITS-1:0] s);
    sec_to_ms = MS_BITS'(s) * MS_BITS'(MS_PER_S);
  endfunction

endpackage

FILE: design/pddi_ram.sv
`timescale 1ns / 1ps

module pddi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pddi_front.sv
`timescale 1ns / 1ps

module pddi_front #(
  parameter int TIME_BITS   = pddi_pkg::DEF_TIME_BITS,
  parameter int HANDLE_BITS = pddi_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pddi_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [TIME_BITS-1:0]          now_ms_i,
  input  logic [HANDLE_BITS-1:0]        pkt_handle_i,
  input  logic                          filter_hit_i,
  input  logic [pddi_pkg::PCT_BITS-1:0] random_pct_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_pop_i,
  output pddi_pkg::cmd_ctl_t            cmd_ctl_o,
  output logic [TIME_BITS-1:0]          cmd_now_o,
  output logic [TIME_BITS-1:0]          cmd_rel_o,
  output logic [HANDLE_BITS-1:0]        cmd_handle_o
);

  localparam int PTR_BITS = $clog2(pddi_pkg::CMDQ_DEPTH);
  localparam int CNT_BITS = $clog2(pddi_pkg::CMDQ_DEPTH + 1);

  pddi_pkg::cmd_ctl_t     ctl_mem    [pddi_pkg::CMDQ_DEPTH];
  logic [TIME_BITS-1:0]   now_mem    [pddi_pkg::CMDQ_DEPTH];
  logic [TIME_BITS-1:0]   rel_mem    [pddi_pkg::CMDQ_DEPTH];
  logic [HANDLE_BITS-1:0] handle_mem [pddi_pkg::CMDQ_DEPTH];

  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                push;

  pddi_pkg::cmd_ctl_t     ctl_new;
  logic [TIME_BITS:0]     rel_sum;
  logic [TIME_BITS-1:0]   rel_new;

  assign in_stall_o  = (cnt_q == CNT_BITS'(pddi_pkg::CMDQ_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);

  // unused code 3 behaves as a tick
  always_comb begin
    ctl_new.is_pkt   = (req_type_i == pddi_pkg::REQ_PACKET);
    ctl_new.is_flush = (req_type_i == pddi_pkg::REQ_FLUSH);
    ctl_new.hit      = filter_hit_i;
    ctl_new.rnd      = random_pct_i;
  end

  // release time saturates at the top of the time range
  assign rel_sum = {1'b0, now_ms_i}
                 + (TIME_BITS+1)'(pddi_pkg::sec_to_ms(cfg_i.hold_seconds));
  assign rel_new = rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_mem[wr_ptr_q]    <= ctl_new;
      now_mem[wr_ptr_q]    <= now_ms_i;
      rel_mem[wr_ptr_q]    <= rel_new;
      handle_mem[wr_ptr_q] <= pkt_handle_i;
    end
  end

  assign cmd_ctl_o    = ctl_mem[rd_ptr_q];
  assign cmd_now_o    = now_mem[rd_ptr_q];
  assign cmd_rel_o    = rel_mem[rd_ptr_q];
  assign cmd_handle_o = handle_mem[rd_ptr_q];

endmodule

FILE: design/pddi_back.sv
`timescale 1ns / 1ps

module pddi_back #(
  parameter int QUEUE_DEPTH = pddi_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = pddi_pkg::DEF_TIME_BITS,
  parameter int HANDLE_BITS = pddi_pkg::DEF_HANDLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pddi_pkg::cfg_t         cfg_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_pop_o,
  input  pddi_pkg::cmd_ctl_t     cmd_ctl_i,
  input  logic [TIME_BITS-1:0]   cmd_now_i,
  input  logic [TIME_BITS-1:0]   cmd_rel_i,
  input  logic [HANDLE_BITS-1:0] cmd_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             action_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   is_last_o
);

  localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_BITS = HANDLE_BITS + TIME_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_q, state_d;

  // request being worked on
  pddi_pkg::cmd_ctl_t     cur_ctl_q;
  logic [TIME_BITS-1:0]   cur_now_q, cur_rel_q;
  logic [HANDLE_BITS-1:0] cur_handle_q;

  // held queue bookkeeping
  logic [IDX_BITS-1:0] head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
  logic [CNT_BITS-1:0] count_q, count_d;

  // release found but not yet sent, so its last flag can be settled
  logic                   pend_v_q, pend_v_d;
  logic [HANDLE_BITS-1:0] pend_h_q, pend_h_d;

  // read of an entry written in the same cycle
  logic                 byp_v_q, byp_v_d;
  logic [WORD_BITS-1:0] byp_word_q;

  logic [TIME_BITS-1:0]          burst_start_q, burst_start_d;
  logic [TIME_BITS-1:0]          sec_start_q, sec_start_d;
  logic [pddi_pkg::SEC_BITS-1:0] drops_q, drops_d;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             action_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   last_q;

  logic                   emit;
  logic [1:0]             emit_action;
  logic [HANDLE_BITS-1:0] emit_handle;
  logic                   emit_last;

  logic                 ram_we, ram_re;
  logic [IDX_BITS-1:0]  ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, look_word;
  logic [TIME_BITS-1:0]   look_time;
  logic [HANDLE_BITS-1:0] look_handle;

  logic slot_free, rel_ok, take;

  // decision terms
  logic [TIME_BITS-1:0]          sec_el, burst_el;
  logic [TIME_BITS-1:0]          period_ms, burst_ms;
  logic                          sec_roll, cnt_drop, do_drop, burst_roll, in_burst, do_queue;
  logic [pddi_pkg::SEC_BITS-1:0] drops_eff;
  logic [1:0]                    decide_action;

  pddi_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata   = {cur_handle_q, cur_rel_q};
  assign look_word   = byp_v_q ? byp_word_q : ram_rdata;
  assign look_time   = look_word[TIME_BITS-1:0];
  assign look_handle = look_word[WORD_BITS-1:TIME_BITS];

  assign head_inc = (head_q == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign rel_ok    = (count_q != '0) && (cur_ctl_q.is_flush || look_time <= cur_now_q);

  // drop and delay decision for the current packet
  always_comb begin
    period_ms  = TIME_BITS'(pddi_pkg::sec_to_ms(cfg_i.window_period_s));
    burst_ms   = TIME_BITS'(pddi_pkg::sec_to_ms(cfg_i.window_burst_s));
    sec_el     = cur_now_q - sec_start_q;
    sec_roll   = sec_el >= TIME_BITS'(pddi_pkg::MS_PER_S);
    drops_eff  = sec_roll ? '0 : drops_q;
    cnt_drop   = drops_eff < cfg_i.drops_per_second;
    do_drop    = cur_ctl_q.hit && cfg_i.drop_on &&
                 (cfg_i.drop_by_percent ? (cur_ctl_q.rnd < cfg_i.drop_chance) : cnt_drop);
    burst_el   = cur_now_q - burst_start_q;
    burst_roll = (period_ms != '0) && (burst_el >= period_ms);
    in_burst   = (burst_roll ? '0 : burst_el) < burst_ms;
    do_queue   = cur_ctl_q.hit && !do_drop && cfg_i.delay_on && in_burst &&
                 (cfg_i.hold_seconds != '0) && (count_q < CNT_BITS'(QUEUE_DEPTH));
    priority if (do_drop) begin
      decide_action = pddi_pkg::ACT_DROP;
    end else if (do_queue) begin
      decide_action = pddi_pkg::ACT_QUEUE;
    end else begin
      decide_action = pddi_pkg::ACT_FORWARD;
    end
  end

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    pend_v_d      = pend_v_q;
    pend_h_d      = pend_h_q;
    burst_start_d = burst_start_q;
    sec_start_d   = sec_start_q;
    drops_d       = drops_q;
    emit          = 1'b0;
    emit_action   = pddi_pkg::ACT_RELEASE;
    emit_handle   = pend_h_q;
    emit_last     = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = head_q;
    take          = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          take    = 1'b1;
          ram_re  = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!pend_v_q || slot_free) begin
          emit = pend_v_q;
          if (rel_ok) begin
            pend_v_d  = 1'b1;
            pend_h_d  = look_handle;
            head_d    = head_inc;
            count_d   = count_q - 1'b1;
            ram_re    = 1'b1;
            ram_raddr = head_inc;
          end else begin
            pend_v_d  = 1'b0;
            emit_last = !cur_ctl_q.is_pkt;
            if (cur_ctl_q.is_pkt) begin
              state_d = S_DECIDE;
            end else if (cmd_valid_i) begin
              take   = 1'b1;
              ram_re = 1'b1;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_DECIDE: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_action = decide_action;
          emit_handle = cur_handle_q;
          emit_last   = 1'b1;
          if (cur_ctl_q.hit && cfg_i.drop_on && !cfg_i.drop_by_percent) begin
            if (sec_roll) begin
              sec_start_d = cur_now_q;
            end
            drops_d = cnt_drop ? drops_eff + 1'b1 : drops_eff;
          end
          if (cur_ctl_q.hit && !do_drop && cfg_i.delay_on && burst_roll) begin
            burst_start_d = cur_now_q;
          end
          if (do_queue) begin
            ram_we  = 1'b1;
            tail_d  = tail_inc;
            count_d = count_q + 1'b1;
          end
          if (cmd_valid_i) begin
            take    = 1'b1;
            ram_re  = 1'b1;
            state_d = S_LOOK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_pop_o = take;
  assign byp_v_d   = ram_re ? (ram_we && (ram_raddr == tail_q)) : byp_v_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      pend_v_q      <= 1'b0;
      byp_v_q       <= 1'b0;
      burst_start_q <= '0;
      sec_start_q   <= '0;
      drops_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      pend_v_q      <= pend_v_d;
      byp_v_q       <= byp_v_d;
      burst_start_q <= burst_start_d;
      sec_start_q   <= sec_start_d;
      drops_q       <= drops_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_h_q <= pend_h_d;
    if (ram_re && ram_we) begin
      byp_word_q <= ram_wdata;
    end
    if (take) begin
      cur_ctl_q    <= cmd_ctl_i;
      cur_now_q    <= cmd_now_i;
      cur_rel_q    <= cmd_rel_i;
      cur_handle_q <= cmd_handle_i;
    end
    if (emit) begin
      action_q <= emit_action;
      handle_q <= emit_handle;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign out_handle_o = handle_q;
  assign is_last_o    = last_q;

endmodule

FILE: design/packet_drop_delay_impairment.sv
`timescale 1ns / 1ps

// Packet drop / delay impairment.
// Input channel (in_valid_i / in_stall_o) takes one request per accept: a packet
// arrival, a tick or a flush, each with the current millisecond time. Output
// channel (out_valid_o / out_stall_i) returns the results of each request in
// order, is_last_o marking the final one: first every held descriptor whose
// release time has come (all of them for a flush), then for a packet its own
// action (forward, drop or queue). A tick or flush that releases nothing gives
// no result. Registers are written through cfg_we_i / cfg_addr_i / cfg_data_i;
// the user must write them only while no request is in progress, which the
// block itself does not enforce. A request is registered in the front buffer
// before the sequencer takes it. In the sequencer a tick or flush passes the
// look state and a packet the look and decide states, plus a look step per
// released descriptor and an idle step when the sequencer was idle; the
// release rate is set by the head read of the held-descriptor RAM. Up to two
// requests wait in the front buffer; in_stall_o rises when it is full.
// While out_stall_i is high the current result waits in the output register
// and the sequencer stops before its next result. Reset empties the queue,
// clears all registers and starts both time windows at time 0.
module packet_drop_delay_impairment #(
  parameter int QUEUE_DEPTH = pddi_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = pddi_pkg::DEF_TIME_BITS,
  parameter int HANDLE_BITS = pddi_pkg::DEF_HANDLE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pddi_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [pddi_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [TIME_BITS-1:0]               now_ms_i,
  input  logic [HANDLE_BITS-1:0]             pkt_handle_i,
  input  logic                               filter_hit_i,
  input  logic [pddi_pkg::PCT_BITS-1:0]      random_pct_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         action_o,
  output logic [HANDLE_BITS-1:0]             out_handle_o,
  output logic                               is_last_o
);

  pddi_pkg::cfg_t cfg_q, cfg_d;

  logic                   cmd_valid, cmd_pop;
  pddi_pkg::cmd_ctl_t     cmd_ctl;
  logic [TIME_BITS-1:0]   cmd_now, cmd_rel;
  logic [HANDLE_BITS-1:0] cmd_handle;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pddi_pkg::CFG_DROP_ON:         cfg_d.drop_on          = cfg_data_i[0];
        pddi_pkg::CFG_DROP_BY_PERCENT: cfg_d.drop_by_percent  = cfg_data_i[0];
        pddi_pkg::CFG_DROPS_PER_SEC:   cfg_d.drops_per_second = cfg_data_i;
        pddi_pkg::CFG_DROP_CHANCE:     cfg_d.drop_chance      = cfg_data_i[pddi_pkg::PCT_BITS-1:0];
        pddi_pkg::CFG_DELAY_ON:        cfg_d.delay_on         = cfg_data_i[0];
        pddi_pkg::CFG_WINDOW_PERIOD:   cfg_d.window_period_s  = cfg_data_i;
        pddi_pkg::CFG_WINDOW_BURST:    cfg_d.window_burst_s   = cfg_data_i;
        pddi_pkg::CFG_HOLD_SECONDS:    cfg_d.hold_seconds     = cfg_data_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pddi_front #(
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .now_ms_i     (now_ms_i),
    .pkt_handle_i (pkt_handle_i),
    .filter_hit_i (filter_hit_i),
    .random_pct_i (random_pct_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_ctl_o    (cmd_ctl),
    .cmd_now_o    (cmd_now),
    .cmd_rel_o    (cmd_rel),
    .cmd_handle_o (cmd_handle)
  );

  pddi_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_ctl_i    (cmd_ctl),
    .cmd_now_i    (cmd_now),
    .cmd_rel_i    (cmd_rel),
    .cmd_handle_i (cmd_handle),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .out_handle_o (out_handle_o),
    .is_last_o    (is_last_o)
  );

endmodule
